FILE: src/agwu_pkg.sv
// Shared constants and types for the adaptive gradient weight update block.
package agwu_pkg;

  localparam int NUM_ELEMS = 1024;
  localparam int ADDR_W    = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;
  localparam int IDX_W     = 10;
  localparam int DATA_W    = 32;
  localparam int RATE_W    = 16;
  localparam int EPS_W     = 31;
  localparam int DECAY_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;
  localparam int RAM_W     = DATA_W + 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd2;

  localparam logic [RATE_W-1:0]  RATE_RST  = 16'd655;
  localparam logic [EPS_W-1:0]   EPS_RST   = 31'd32768;
  localparam logic [DECAY_W-1:0] DECAY_RST = 16'd19661;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // Iteration counts and widths of the back end.
  localparam int SQ_ITER  = 24;
  localparam int NUM_W    = 48;
  localparam int DIV_ITER = NUM_W;
  localparam int STEP_W   = 34;
  localparam logic [STEP_W-1:0] STEP_CLAMP = 34'h2_0000_0000;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] w;
    logic signed [DATA_W-1:0] g;
    logic                     in_range;
  } item_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [EPS_W-1:0]   eps;
    logic [DECAY_W-1:0] decay;
  } cfg_t;

endpackage

FILE: src/agwu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module agwu_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/agwu_front.sv
// Front end: accepts items, checks the index range and queues them for the back end.
module agwu_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic [agwu_pkg::IDX_W-1:0]  in_elem_index,
  input  logic signed [agwu_pkg::DATA_W-1:0] in_weight_in,
  input  logic signed [agwu_pkg::DATA_W-1:0] in_gradient,
  output logic                      in_full,
  input  logic                      clearing,
  input  logic                      deq,
  output logic                      q_valid,
  output agwu_pkg::item_t           q_item
);
  import agwu_pkg::*;

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, wp_nxt;
  logic [Q_PTR_W-1:0] rp_r, rp_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;
  logic               push;
  logic               pop;
  item_t              new_item;

  assign in_full = (cnt_r == (Q_PTR_W + 1)'(Q_DEPTH)) || clearing;
  assign push    = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign pop     = deq && q_valid;
  assign q_item  = mem_r[rp_r];

  // Classify the incoming item.
  always_comb begin
    new_item.idx      = in_elem_index;
    new_item.w        = in_weight_in;
    new_item.g        = in_gradient;
    new_item.in_range = (32'(in_elem_index) < NUM_ELEMS);
  end

  // Pointer and count update.
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (Q_PTR_W + 1)'(push) - (Q_PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= new_item;
    end
  end

endmodule

FILE: src/agwu_back.sv
// Back end: per-element state lookup, square root, division, accumulator update and result.
module agwu_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  agwu_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  input  agwu_pkg::item_t               q_item,
  output logic                          deq,
  output logic                          clearing,
  output logic                          ram_we,
  output logic [agwu_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [agwu_pkg::RAM_W-1:0]    ram_wdata,
  output logic                          ram_re,
  output logic [agwu_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic [agwu_pkg::RAM_W-1:0]    ram_rdata,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic signed [agwu_pkg::DATA_W-1:0] out_weight_out,
  output logic [agwu_pkg::IDX_W-1:0]    out_index
);
  import agwu_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_MULN = 4'd3;
  localparam logic [3:0] S_MULG = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_DEN  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_ACC1 = 4'd8;
  localparam logic [3:0] S_ACC2 = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]            state_r, state_nxt;
  logic [5:0]            cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  item_t                 item_r, item_nxt;
  logic [DATA_W-1:0]     mag_r, mag_nxt;
  logic                  seen_r, seen_nxt;
  logic [DATA_W-1:0]     acc_r, acc_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [DATA_W-1:0]     gsq_r, gsq_nxt;
  logic [NUM_W-1:0]      x_r, x_nxt;
  logic [SQ_ITER-1:0]    root_r, root_nxt;
  logic [SQ_ITER+2:0]    srem_r, srem_nxt;
  logic [DATA_W-1:0]     den_r, den_nxt;
  logic [DATA_W-1:0]     drem_r, drem_nxt;
  logic [NUM_W-1:0]      quo_r, quo_nxt;
  logic [NUM_W-1:0]      nsh_r, nsh_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [NUM_W:0]        p1_r, p1_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_w_r, out_w_nxt;
  logic [IDX_W-1:0]      out_idx_r, out_idx_nxt;

  logic [SQ_ITER+2:0]    sq_rem2;
  logic [SQ_ITER+2:0]    sq_trial;
  logic                  sq_ge;
  logic [DATA_W:0]       dv_rem2;
  logic                  dv_ge;
  logic [2*DATA_W-1:0]   sq_prod;
  logic [NUM_W+1:0]      acc_sum;
  logic [STEP_W:0]       w_sum;
  logic                  slot_free;

  assign clearing       = (state_r == S_CLR);
  assign out_empty      = !out_valid_r;
  assign out_weight_out = out_w_r;
  assign out_index      = out_idx_r;
  assign slot_free      = !out_valid_r || out_pop;
  assign ram_raddr      = ADDR_W'(q_item.idx);

  // One step of the digit-by-digit square root.
  always_comb begin
    sq_rem2  = {srem_r[SQ_ITER:0], x_r[NUM_W-1 -: 2]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_ge    = (sq_rem2 >= sq_trial);
  end

  // One step of the restoring divider.
  always_comb begin
    dv_rem2 = {drem_r, nsh_r[NUM_W-1]};
    dv_ge   = (dv_rem2 >= {1'b0, den_r});
  end

  assign sq_prod = 64'(mag_r) * 64'(mag_r);
  assign acc_sum = (NUM_W + 2)'(p1_r) + (NUM_W + 2)'(48'(cfg.decay) * 48'(gsq_r));

  // Signed step applied to the weight, in a width that cannot overflow.
  always_comb begin
    if (item_r.g[DATA_W-1]) begin
      w_sum = (STEP_W + 1)'(item_r.w) + (STEP_W + 1)'(step_r);
    end else begin
      w_sum = (STEP_W + 1)'(item_r.w) - (STEP_W + 1)'(step_r);
    end
  end

  // Sequencer for one item at a time.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_addr_nxt  = clr_addr_r;
    item_nxt      = item_r;
    mag_nxt       = mag_r;
    seen_nxt      = seen_r;
    acc_nxt       = acc_r;
    num_nxt       = num_r;
    gsq_nxt       = gsq_r;
    x_nxt         = x_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    den_nxt       = den_r;
    drem_nxt      = drem_r;
    quo_nxt       = quo_r;
    nsh_nxt       = nsh_r;
    step_nxt      = step_r;
    p1_nxt        = p1_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_w_nxt     = out_w_r;
    out_idx_nxt   = out_idx_r;
    deq           = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ADDR_W'(item_r.idx);
    ram_wdata     = '0;

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        if (32'(clr_addr_r) == NUM_ELEMS - 1) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          deq       = 1'b1;
          ram_re    = q_item.in_range;
          item_nxt  = q_item;
          mag_nxt   = q_item.g[DATA_W-1] ? DATA_W'(-q_item.g) : DATA_W'(q_item.g);
          step_nxt  = '0;
          state_nxt = q_item.in_range ? S_RD : S_FIN;
        end
      end
      S_RD: begin
        seen_nxt  = ram_rdata[RAM_W-1];
        acc_nxt   = ram_rdata[DATA_W-1:0];
        state_nxt = S_MULN;
      end
      S_MULN: begin
        num_nxt   = NUM_W'(cfg.rate) * NUM_W'(mag_r);
        state_nxt = S_MULG;
      end
      S_MULG: begin
        gsq_nxt = (sq_prod[63:48] != '0) ? '1 : sq_prod[47:16];
        if (!seen_r) begin
          // First visit: plain scaled step and a fresh accumulator.
          step_nxt  = STEP_W'(num_r >> 16);
          ram_we    = 1'b1;
          ram_wdata = {1'b1, ((sq_prod[63:48] != '0) ? {DATA_W{1'b1}} : sq_prod[47:16])};
          state_nxt = S_FIN;
        end else begin
          x_nxt     = {acc_r, 16'd0};
          root_nxt  = '0;
          srem_nxt  = '0;
          cnt_nxt   = 6'(SQ_ITER - 1);
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        x_nxt    = x_r << 2;
        root_nxt = {root_r[SQ_ITER-2:0], sq_ge};
        srem_nxt = sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
        if (cnt_r == '0) begin
          state_nxt = S_DEN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DEN: begin
        den_nxt   = DATA_W'(root_r) + DATA_W'(cfg.eps);
        drem_nxt  = '0;
        quo_nxt   = '0;
        nsh_nxt   = num_r;
        cnt_nxt   = 6'(DIV_ITER - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        nsh_nxt  = nsh_r << 1;
        quo_nxt  = {quo_r[NUM_W-2:0], dv_ge};
        drem_nxt = dv_ge ? DATA_W'(dv_rem2 - {1'b0, den_r}) : dv_rem2[DATA_W-1:0];
        if (cnt_r == '0) begin
          state_nxt = S_ACC1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_ACC1: begin
        // A zero numerator gives no step; a zero denominator runs to the clamp.
        priority if (num_r == '0) begin
          step_nxt = '0;
        end else if (quo_r > NUM_W'(STEP_CLAMP)) begin
          step_nxt = STEP_CLAMP;
        end else begin
          step_nxt = quo_r[STEP_W-1:0];
        end
        p1_nxt    = (NUM_W + 1)'((17'h1_0000 - 17'(cfg.decay)) * 49'(acc_r));
        state_nxt = S_ACC2;
      end
      S_ACC2: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, ((acc_sum[NUM_W+1:48] != '0) ? {DATA_W{1'b1}} : acc_sum[47:16])};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = item_r.idx;
          priority if (!w_sum[STEP_W] && (w_sum[STEP_W-1:DATA_W-1] != '0)) begin
            out_w_nxt = {1'b0, {(DATA_W-1){1'b1}}};
          end else if (w_sum[STEP_W] && (w_sum[STEP_W-1:DATA_W-1] != '1)) begin
            out_w_nxt = {1'b1, {(DATA_W-1){1'b0}}};
          end else begin
            out_w_nxt = w_sum[DATA_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    item_r    <= item_nxt;
    mag_r     <= mag_nxt;
    seen_r    <= seen_nxt;
    acc_r     <= acc_nxt;
    num_r     <= num_nxt;
    gsq_r     <= gsq_nxt;
    x_r       <= x_nxt;
    root_r    <= root_nxt;
    srem_r    <= srem_nxt;
    den_r     <= den_nxt;
    drem_r    <= drem_nxt;
    quo_r     <= quo_nxt;
    nsh_r     <= nsh_nxt;
    step_r    <= step_nxt;
    p1_r      <= p1_nxt;
    out_w_r   <= out_w_nxt;
    out_idx_r <= out_idx_nxt;
  end

endmodule

FILE: src/adaptive_gradient_weight_update.sv
// Top level of the adaptive gradient weight update block.
// RMSprop-style update of one weight per item, with a squared-gradient accumulator and a seen
// flag per element held in one 1024-entry RAM. After reset a clearing pass writes every RAM
// entry, one per cycle; in_full stays high until it ends. Items enter a four-deep queue at one
// per cycle while it has room. The back end then works one item at a time; any item but a first
// visit of an element or an out-of-range index runs the 24-step square root and the 48-step
// divider in sequence. A finished result waits in an output register while the next item is
// started.
module adaptive_gradient_weight_update (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [agwu_pkg::IDX_W-1:0]         in_elem_index,
  input  logic signed [agwu_pkg::DATA_W-1:0] in_weight_in,
  input  logic signed [agwu_pkg::DATA_W-1:0] in_gradient,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic signed [agwu_pkg::DATA_W-1:0] out_weight_out,
  output logic [agwu_pkg::IDX_W-1:0]         out_index,
  input  logic                               cfg_we,
  input  logic [agwu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [agwu_pkg::CFG_W-1:0]         cfg_wdata
);
  import agwu_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  logic              q_valid;
  item_t             q_item;
  logic              deq;
  logic              clearing;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [RAM_W-1:0]  ram_rdata;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RATE:  cfg_nxt.rate  = cfg_wdata[RATE_W-1:0];
        CFG_EPS:   cfg_nxt.eps   = cfg_wdata[EPS_W-1:0];
        CFG_DECAY: cfg_nxt.decay = cfg_wdata[DECAY_W-1:0];
        default:   cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate  <= RATE_RST;
      cfg_r.eps   <= EPS_RST;
      cfg_r.decay <= DECAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  agwu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_elem_index (in_elem_index),
    .in_weight_in  (in_weight_in),
    .in_gradient   (in_gradient),
    .in_full       (in_full),
    .clearing      (clearing),
    .deq           (deq),
    .q_valid       (q_valid),
    .q_item        (q_item)
  );

  agwu_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_ELEMS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  agwu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .deq            (deq),
    .clearing       (clearing),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_weight_out (out_weight_out),
    .out_index      (out_index)
  );

`ifndef ASSERT_OFF
  // The clearing pass blocks input right after reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input not blocked during clearing pass");

  // No result is waiting right after reset.
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  // The state RAM is never read and written in the same cycle.
  a_ram_exclusive: assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
    else $error("state RAM read and write collide");

  // An item leaves the queue only once clearing is done.
  a_no_deq_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !deq)
    else $error("item taken during clearing pass");
`endif

endmodule

FILE: bench/adaptive_gradient_weight_update_tb.sv
// Self-checking testbench for the adaptive gradient weight update block.
`timescale 1ns / 1ps

module adaptive_gradient_weight_update_tb;
  import agwu_pkg::*;

  localparam int IDLE_LIMIT  = 6000;
  localparam int DRAIN_WAIT  = 120;
  localparam int LONG_HOLD   = 400;
  localparam int RAND_PER_PH = 140;
  localparam logic [63:0] MAX_STEP = 64'h2_0000_0000;

  logic                       clk;
  logic                       rst_n;
  logic                       in_push;
  logic                       in_full;
  logic [IDX_W-1:0]           in_elem_index;
  logic signed [DATA_W-1:0]   in_weight_in;
  logic signed [DATA_W-1:0]   in_gradient;
  logic                       out_empty;
  logic                       out_pop;
  logic signed [DATA_W-1:0]   out_weight_out;
  logic [IDX_W-1:0]           out_index;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_wdata;

  adaptive_gradient_weight_update dut (.*);

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] w;
  } update_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] w;
    logic [DATA_W-1:0] g;
    bit                fixed;
    logic [DATA_W-1:0] fixed_w;
  } vector_t;

  // Shadow copy of the block's registers and per-element state.
  logic [RATE_W-1:0]  rate_q;
  logic [EPS_W-1:0]   eps_q;
  logic [DECAY_W-1:0] decay_q;
  logic [DATA_W-1:0]  acc_mem [NUM_ELEMS];
  bit                 seen_mem [NUM_ELEMS];

  update_t pending_updates[$];
  int      errors;
  int      items_in;
  int      results_out;
  int      idle_cycles;
  int      in_taken;
  bit      cur_fixed;
  logic [DATA_W-1:0] cur_fixed_w;
  bit      hold_req;
  int      stall_mode;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // Predicts the new weight and advances the shadow state of one element.
  function automatic logic [DATA_W-1:0] next_weight(input logic [IDX_W-1:0] idx,
                                                    input logic [DATA_W-1:0] w,
                                                    input logic [DATA_W-1:0] g);
    logic               neg;
    logic [63:0]        mag, num, gsq, stepmag, acc, den;
    logic signed [63:0] nw;
    neg = g[31];
    mag = neg ? (64'h1_0000_0000 - {32'b0, g}) : {32'b0, g};
    num = 64'(rate_q) * mag;
    gsq = (mag * mag) >> 16;
    if (gsq > 64'hFFFF_FFFF) gsq = 64'hFFFF_FFFF;
    if (!seen_mem[idx]) begin
      stepmag = num >> 16;
      acc_mem[idx] = gsq[31:0];
      seen_mem[idx] = 1'b1;
    end else begin
      acc = {32'b0, acc_mem[idx]};
      den = int_sqrt(acc << 16) + 64'(eps_q);
      if (den == 0) stepmag = (num != 0) ? MAX_STEP : 64'd0;
      else stepmag = num / den;
      acc = ((64'd65536 - 64'(decay_q)) * acc + 64'(decay_q) * gsq) >> 16;
      if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      acc_mem[idx] = acc[31:0];
    end
    if (stepmag > MAX_STEP) stepmag = MAX_STEP;
    nw = $signed({{32{w[31]}}, w});
    nw = neg ? nw + $signed(stepmag) : nw - $signed(stepmag);
    if (nw > 64'sh7FFF_FFFF) nw = 64'sh7FFF_FFFF;
    if (nw < -64'sh8000_0000) nw = -64'sh8000_0000;
    return nw[31:0];
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  // Monitor: tracks register writes, predicts each input transfer and checks each result.
  always @(posedge clk) begin
    update_t e;
    logic [DATA_W-1:0] w;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RATE:  rate_q  <= cfg_wdata[RATE_W-1:0];
          CFG_EPS:   eps_q   <= cfg_wdata[EPS_W-1:0];
          CFG_DECAY: decay_q <= cfg_wdata[DECAY_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        w = next_weight(in_elem_index, in_weight_in, in_gradient);
        if (cur_fixed) w = cur_fixed_w;
        pending_updates.push_back('{idx: in_elem_index, w: w});
        items_in++;
        in_taken++;
        moved = 1'b1;
      end
      if (out_pop && !out_empty) begin
        moved = 1'b1;
        results_out++;
        if (pending_updates.size() == 0) begin
          report("unexpected result, index", 64'(out_index), 0);
        end else begin
          e = pending_updates.pop_front();
          if (out_weight_out !== e.w) report("weight_out", 64'(out_weight_out), 64'(e.w));
          if (out_index !== e.idx) report("out_index", 64'(out_index), 64'(e.idx));
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] timeout: no transfer for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: a randomly chosen stall pattern, plus a long hold on request.
  initial begin
    int cyc;
    int held;
    out_pop = 1'b0;
    cyc = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_req) begin
        out_pop = 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(negedge clk);
        hold_req = 1'b0;
      end
      case (stall_mode)
        0, 1:    out_pop = 1'b1;
        2:       out_pop = ($urandom_range(0, 1) == 1);
        default: out_pop = (cyc % 3 == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Waits until every expected update has come back, then lets the back end settle.
  task automatic drain();
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Offers one item at the falling edge and holds it until the transfer happens.
  task automatic send(input vector_t v);
    int start;
    start = in_taken;
    cur_fixed = v.fixed;
    cur_fixed_w = v.fixed_w;
    in_push = 1'b1;
    in_elem_index = v.idx;
    in_weight_in = v.w;
    in_gradient = v.g;
    do @(negedge clk); while (in_taken == start);
    cur_fixed = 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_grad(input bit zero_heavy);
    logic [DATA_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, zero_heavy ? 9 : 5))
      0:       return 32'h0;
      1:       return v;
      2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3:       return $signed(v) >>> $urandom_range(8, 31);
      4, 5:    return $signed(v) >>> $urandom_range(0, 16);
      default: return 32'h0;
    endcase
  endfunction

  function automatic vector_t rand_item(input bit zero_heavy);
    vector_t v;
    v.idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       v.w = 32'h7FFF_FFFF;
      1:       v.w = 32'h8000_0000;
      default: v.w = $urandom;
    endcase
    v.g = rand_grad(zero_heavy);
    v.fixed = 1'b0;
    v.fixed_w = '0;
    return v;
  endfunction

  // Directed vectors; the fixed column holds results that follow directly from the math.
  vector_t directed_vecs[] = '{
    '{10'd0,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{10'd0,    32'h0001_0000, 32'h0000_0000, 1'b1, 32'h0001_0000},
    '{10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF},
    '{10'd1022, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
    '{10'd1023, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{10'd1022, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0},
    '{10'd3,    32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0},
    '{10'd3,    32'h0001_0000, 32'hFFFF_0000, 1'b0, 32'h0},
    '{10'd3,    32'hFFFF_FFFF, 32'h0002_0000, 1'b0, 32'h0},
    '{10'd512,  32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0},
    '{10'd512,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{10'd7,    32'h1234_5678, 32'hFFFF_0000, 1'b0, 32'h0},
    '{10'd7,    32'hEDCB_A987, 32'h0000_8000, 1'b0, 32'h0},
    '{10'd7,    32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
    '{10'd341,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0},
    '{10'd682,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0}
  };

  // Register settings of the random phases: rate, epsilon, decay.
  logic [CFG_W-1:0] phase_cfg [4][3] = '{
    '{31'd65535, 31'd0,          31'd0},
    '{31'd0,     31'h7FFF_FFFF, 31'd65535},
    '{31'd1000,  31'd65536,      31'd32768},
    '{31'd655,   31'd32768,      31'd19661}
  };

  // Main sequence: reset, directed vectors, then random phases under several settings.
  initial begin
    int burst;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_elem_index = '0;
    in_weight_in = '0;
    in_gradient = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_RATE;
    cfg_wdata = '0;
    rate_q = RATE_RST;
    eps_q = EPS_RST;
    decay_q = DECAY_RST;
    for (int i = 0; i < NUM_ELEMS; i++) seen_mem[i] = 1'b0;
    errors = 0;
    items_in = 0;
    results_out = 0;
    idle_cycles = 0;
    in_taken = 0;
    cur_fixed = 1'b0;
    cur_fixed_w = '0;
    hold_req = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_vecs[i]) send(directed_vecs[i]);
    in_push = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(CFG_RATE,  phase_cfg[ph][0]);
      write_reg(CFG_EPS,   phase_cfg[ph][1]);
      write_reg(CFG_DECAY, phase_cfg[ph][2]);
      if (ph == 1) hold_req = 1'b1;
      burst = $urandom_range(1, 16);
      for (int n = 0; n < RAND_PER_PH + 30 * (ph == 0); n++) begin
        send(rand_item(ph == 0));
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 16);
          if (ph != 2 && $urandom_range(0, 2) != 0) begin
            in_push = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
          end
        end
        // Let the block run completely dry once in the middle of a phase.
        if (ph == 3 && n == RAND_PER_PH / 2) begin
          in_push = 1'b0;
          while (pending_updates.size() != 0) @(negedge clk);
        end
      end
      in_push = 1'b0;
    end

    drain();
    $display("Covered %0d updates and %0d results over reset and four register settings,",
             items_in, results_out);
    $display("including zero epsilon, saturating steps, long output stalls and a full drain.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/agwu_pkg.sv
src/agwu_ram.sv
src/agwu_front.sv
src/agwu_back.sv
src/adaptive_gradient_weight_update.sv
bench/adaptive_gradient_weight_update_tb.sv
